>>> design/tfb_pkg.sv
// Package: types, constants and state codes for the timestamp frame buffer.
package tfb_pkg;

  localparam int TfbDepth       = 32;
  localparam int TfbHandleWidth = 8;
  localparam int TfbFactorBits  = 16;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_TAKE   = 2'd1;
  localparam logic [1:0] FUNC_PAIR   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] time_ms;
    logic [7:0]  frame_handle;
  } tfb_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_handle;
    logic [31:0] found_time;
    logic [7:0]  later_handle;
    logic [16:0] blend_factor;
    logic [5:0]  entry_count;
    logic [31:0] span_ms;
  } tfb_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_REQ,
    ST_SCAN,
    ST_INS_SHIFT,
    ST_INS_WRITE,
    ST_TAKE_MOVE,
    ST_PAIR_RD,
    ST_DIV,
    ST_SPAN_RD,
    ST_SPAN,
    ST_DONE
  } tfb_state_t;

endpackage

>>> design/timestamp_frame_buffer_top.sv
// Top level: timestamp-sorted frame store with a shared compare/subtract unit.
//
// Usage:
//   Input channel: drive in_data with func, time_ms and frame_handle and
//   raise start while busy is low; that edge is the transfer. busy stays
//   high until the result has been shown. Every operation gives exactly one
//   result: out_valid is high for one cycle with out_data, and the receiver
//   must take it then, since it cannot stall the block.
//   One memory port and one compare/subtract unit walk the stored entries
//   one per cycle. The steps of each operation:
//     insert: scan to the slot, then shift the tail up one a cycle,
//     take:   scan, then on a hit move the tail down; a miss is when
//             nothing is at or before the target,
//     pair:   scan, then on a hit the blend divider makes one quotient
//             bit a cycle,
//     clear and a rejected insert: no scan.
//   busy drops the cycle after the strobe, so a new item is taken only
//   once the last one has been answered.
//   Reset clears the count and the last-taken mark; the entry memory is
//   not cleared, since only entries below the count are ever used.
module timestamp_frame_buffer_top
  import tfb_pkg::*;
#(
  parameter int DEPTH        = TfbDepth,
  parameter int HANDLE_WIDTH = TfbHandleWidth,
  parameter int FACTOR_BITS  = TfbFactorBits
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tfb_in_t  in_data,
  output logic     out_valid,
  output tfb_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = 32 + FACTOR_BITS;       // dividend width
  localparam int DCW = $clog2(NW + 1);

  // Entry memory: time and handle, one port shared by scans and moves.
  logic [31:0]             mem_time [DEPTH];
  logic [HANDLE_WIDTH-1:0] mem_frame[DEPTH];
  logic [AW-1:0]           rd_addr;
  logic [31:0]             rd_time_r;
  logic [HANDLE_WIDTH-1:0] rd_frame_r;
  logic                    we;
  logic [AW-1:0]           wr_addr;
  logic [31:0]             wr_time;
  logic [HANDLE_WIDTH-1:0] wr_frame;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_time[wr_addr]  <= wr_time;
      mem_frame[wr_addr] <= wr_frame;
    end
    rd_time_r  <= mem_time[rd_addr];
    rd_frame_r <= mem_frame[rd_addr];
  end

  tfb_state_t state_r, state_nxt;
  logic [1:0]  func_r;
  logic [31:0] tgt_r;
  logic [HANDLE_WIDTH-1:0] hdl_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [32:0] last_taken_r, last_taken_nxt;
  logic [CW-1:0] idx_r, idx_nxt;       // scan / move index
  logic [CW-1:0] pos_r, pos_nxt;       // scan result
  logic [31:0] first_r, first_nxt;     // scratch time
  logic [1:0]  status_r, status_nxt;
  logic [HANDLE_WIDTH-1:0] fh_r, fh_nxt, lh_r, lh_nxt;
  logic [31:0] ft_r, ft_nxt;
  logic [31:0] span_r, span_nxt;
  // Divider: restoring, one quotient bit a cycle.
  logic [NW-1:0] num_r, num_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   den_r, den_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  // Last entry passed by the scan: the taken entry when a take stops.
  logic [31:0]             prev_time_r;
  logic [HANDLE_WIDTH-1:0] prev_frame_r;

  // Shared compare/subtract unit.
  logic [31:0] alu_a, alu_b;
  logic [32:0] alu_diff;
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};

  logic [32:0] rem_sh;
  assign rem_sh = {rem_r, num_r[NW-1]};

  // Scan predicate: entry <= target (insert/take) or entry < target (pair).
  logic scan_stop;
  always_comb begin
    if (func_r == FUNC_PAIR) scan_stop = !alu_diff[32];  // entry >= target
    else                     scan_stop = alu_diff[32] && (alu_diff[31:0] != 32'd0);
    // for insert/take alu = tgt - entry: borrow means entry > target
  end

  always_comb begin
    alu_a = tgt_r;
    alu_b = rd_time_r;
    case (state_r)
      ST_SCAN:    begin
        if (func_r == FUNC_PAIR) begin
          alu_a = rd_time_r; alu_b = tgt_r;
        end
      end
      ST_DIV:     begin alu_a = rem_sh[31:0]; alu_b = den_r; end
      ST_SPAN:    begin alu_a = rd_time_r; alu_b = first_r; end
      ST_PAIR_RD: begin alu_a = rd_time_r; alu_b = first_r; end
      default:    ;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:
        if (start) begin
          case (in_data.func)
            FUNC_CLEAR:  state_nxt = ST_SPAN_RD;
            FUNC_INSERT: state_nxt = (count_r >= CW'(DEPTH)) ? ST_SPAN_RD : ST_SCAN_REQ;
            default:     state_nxt = ST_SCAN_REQ;
          endcase
        end
      ST_SCAN_REQ: state_nxt = ST_SCAN;
      ST_SCAN:
        if (idx_r >= count_r || scan_stop) begin
          case (func_r)
            FUNC_INSERT: state_nxt = ST_INS_SHIFT;
            FUNC_TAKE:   state_nxt = (idx_r == '0) ? ST_SPAN_RD : ST_TAKE_MOVE;
            default:     state_nxt = (count_r < CW'(2) || idx_r == '0 || idx_r >= count_r)
                                     ? ST_SPAN_RD : ST_PAIR_RD;
          endcase
        end
      ST_INS_SHIFT: if (idx_r <= pos_r) state_nxt = ST_INS_WRITE;
      ST_INS_WRITE: state_nxt = ST_SPAN_RD;
      ST_TAKE_MOVE: if (idx_r + pos_r >= count_r) state_nxt = ST_SPAN_RD;
      ST_PAIR_RD:   if (idx_r[0]) state_nxt = ST_DIV;
      ST_DIV:       if (dcnt_r == DCW'(NW - 1)) state_nxt = ST_SPAN_RD;
      ST_SPAN_RD:   state_nxt = ST_SPAN;
      ST_SPAN:      if (idx_r[0]) state_nxt = ST_DONE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    idx_nxt = idx_r; pos_nxt = pos_r; first_nxt = first_r;
    count_nxt = count_r; last_taken_nxt = last_taken_r;
    status_nxt = status_r; fh_nxt = fh_r; lh_nxt = lh_r; ft_nxt = ft_r;
    span_nxt = span_r; num_nxt = num_r; rem_nxt = rem_r; den_nxt = den_r;
    dcnt_nxt = dcnt_r; out_valid_nxt = 1'b0;
    rd_addr = idx_r[AW-1:0];
    we = 1'b0; wr_addr = idx_r[AW-1:0]; wr_time = rd_time_r; wr_frame = rd_frame_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        rd_addr = '0;
        status_nxt = STATUS_OK;
        fh_nxt = '0; lh_nxt = '0; ft_nxt = '0; num_nxt = '0;
        if (start) begin
          if (in_data.func == FUNC_CLEAR) begin
            count_nxt = '0;
            last_taken_nxt = '1;
          end else if (in_data.func == FUNC_INSERT && count_r >= CW'(DEPTH)) begin
            status_nxt = STATUS_FULL;
          end
        end
      end
      ST_SCAN_REQ: begin
        rd_addr = '0;
        idx_nxt = '0;
      end
      ST_SCAN: begin
        // Read for the index after this one while comparing this one.
        rd_addr = AW'(idx_r + CW'(1));
        if (idx_r >= count_r || scan_stop) begin
          pos_nxt = idx_r;
          case (func_r)
            FUNC_INSERT: begin
              idx_nxt = count_r;
              rd_addr = AW'(count_r - CW'(1));
            end
            FUNC_TAKE: begin
              if (idx_r == '0) status_nxt = STATUS_NONE;
              idx_nxt = '0;
              rd_addr = AW'(idx_r);
            end
            default: begin
              if (count_r < CW'(2) || idx_r == '0 || idx_r >= count_r)
                status_nxt = STATUS_NONE;
              idx_nxt = '0;
              rd_addr = AW'(idx_r - CW'(1));
            end
          endcase
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_INS_SHIFT: begin
        // idx points at the slot to fill; rd holds entry idx-1.
        if (idx_r > pos_r) begin
          we = 1'b1;
          wr_addr = AW'(idx_r);
          idx_nxt = idx_r - CW'(1);
          rd_addr = AW'(idx_r - CW'(2));
        end
      end
      ST_INS_WRITE: begin
        we = 1'b1; wr_addr = AW'(pos_r); wr_time = tgt_r; wr_frame = hdl_r;
        count_nxt = count_r + CW'(1);
      end
      ST_TAKE_MOVE: begin
        // First cycle: latch the taken entry (n-1) held from the scan.
        // rd holds entry i+n; move it down to i.
        if (idx_r == '0) begin
          fh_nxt = prev_frame_r;
          ft_nxt = prev_time_r;
          last_taken_nxt = {1'b0, prev_time_r};
        end
        if (idx_r + pos_r < count_r) begin
          we = 1'b1;
          wr_addr = AW'(idx_r);
          idx_nxt = idx_r + CW'(1);
          rd_addr = AW'(idx_r + pos_r + CW'(1));
        end else begin
          count_nxt = count_r - pos_r;
        end
      end
      ST_PAIR_RD: begin
        if (!idx_r[0]) begin
          // rd holds entry k-1
          fh_nxt = rd_frame_r; ft_nxt = rd_time_r; first_nxt = rd_time_r;
          rd_addr = AW'(pos_r);
          idx_nxt = CW'(1);
        end else begin
          lh_nxt = rd_frame_r;
          den_nxt = alu_diff[31:0];
          num_nxt = {tgt_r - first_r, {FACTOR_BITS{1'b0}}};
          rem_nxt = '0;
          dcnt_nxt = '0;
        end
      end
      ST_DIV: begin
        // alu = rem_sh - den on the low bits; a carry out of the shift
        // always means the divisor fits.
        num_nxt = {num_r[NW-2:0], 1'b0};
        if (rem_sh[32] || !alu_diff[32]) begin
          rem_nxt = alu_diff[31:0];
          num_nxt[0] = 1'b1;
        end else begin
          rem_nxt = rem_sh[31:0];
        end
        dcnt_nxt = dcnt_r + DCW'(1);
      end
      ST_SPAN_RD: begin
        rd_addr = '0;
        idx_nxt = '0;
      end
      ST_SPAN: begin
        if (!idx_r[0]) begin
          first_nxt = rd_time_r;
          rd_addr = AW'(count_r - CW'(1));
          idx_nxt = CW'(1);
        end else begin
          span_nxt = (count_r < CW'(2)) ? 32'd0 : alu_diff[31:0];
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Hold each entry the scan passes; the stopping step leaves the last
  // passed entry in place, which is the one a take returns.
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && !(idx_r >= count_r || scan_stop)) begin
      prev_time_r  <= rd_time_r;
      prev_frame_r <= rd_frame_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      last_taken_r <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      last_taken_r <= last_taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      func_r <= in_data.func;
      tgt_r  <= in_data.time_ms;
      hdl_r  <= in_data.frame_handle[HANDLE_WIDTH-1:0];
    end
    idx_r <= idx_nxt; pos_r <= pos_nxt; first_r <= first_nxt;
    status_r <= status_nxt; lh_r <= lh_nxt;
    fh_r <= fh_nxt; ft_r <= ft_nxt;
    span_r <= span_nxt; num_r <= num_nxt; rem_r <= rem_nxt;
    den_r <= den_nxt; dcnt_r <= dcnt_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    out_data = '0;
    out_data.status = status_r;
    out_data.entry_count = 6'(count_r);
    out_data.span_ms = span_r;
    if (status_r == STATUS_OK && func_r != FUNC_INSERT && func_r != FUNC_CLEAR) begin
      out_data.found_handle = 8'(fh_r);
      out_data.found_time = ft_r;
      if (func_r == FUNC_PAIR) begin
        out_data.later_handle = 8'(lh_r);
        out_data.blend_factor = 17'(num_r);
      end
    end
  end

  // A result comes out only while the sequencer is finishing an operation.
  a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_DONE) else $error("stray result strobe");
  // The held count never exceeds the store depth.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("count overflow");
  // An accepted item always makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept lost");

endmodule

>>> bench/timestamp_frame_buffer_top_tb.sv
// Testbench: timestamp frame buffer, checked against a sorted-store predictor.
module timestamp_frame_buffer_top_tb;
  import tfb_pkg::*;

  localparam int Depth = TfbDepth;
  localparam int MaxCycles = 2_000_000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  tfb_in_t  in_data;
  logic     out_valid;
  tfb_out_t out_data;

  timestamp_frame_buffer_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // Predictor state: sorted store, earliest first.
  logic [31:0] store_time[Depth];
  logic [7:0]  store_handle[Depth];
  int          store_count;
  logic [32:0] last_taken;

  tfb_out_t expected_results[$];
  int       error_count;
  int       result_count;
  int       transfer_count;
  int       cycle_count;
  int       full_hits;
  int       none_hits;

  // Directed rows; check_row marks rows whose result is typed in.
  typedef struct {
    tfb_in_t  item;
    bit       check_row;
    tfb_out_t want;
  } directed_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic [31:0] span_now();
    if (store_count < 2) return 32'd0;
    return store_time[store_count-1] - store_time[0];
  endfunction

  // Apply one operation to the predictor and return its result.
  function automatic tfb_out_t buffer_apply(tfb_in_t item);
    tfb_out_t r;
    int pos;
    logic [31:0] tp;
    logic [31:0] tn;
    logic [63:0] num;
    logic [63:0] den;
    r = '0;
    pos = 0;
    case (item.func)
      FUNC_INSERT: begin
        if (store_count >= Depth) begin
          r.status = STATUS_FULL;
        end else begin
          while (pos < store_count && store_time[pos] <= item.time_ms) pos++;
          for (int i = store_count; i > pos; i--) begin
            store_time[i] = store_time[i-1];
            store_handle[i] = store_handle[i-1];
          end
          store_time[pos] = item.time_ms;
          store_handle[pos] = item.frame_handle;
          store_count++;
        end
      end
      FUNC_TAKE: begin
        while (pos < store_count && store_time[pos] <= item.time_ms) pos++;
        if (pos == 0) begin
          r.status = STATUS_NONE;
        end else begin
          r.found_handle = store_handle[pos-1];
          r.found_time = store_time[pos-1];
          last_taken = {1'b0, store_time[pos-1]};
          for (int i = 0; i + pos < store_count; i++) begin
            store_time[i] = store_time[i+pos];
            store_handle[i] = store_handle[i+pos];
          end
          store_count -= pos;
        end
      end
      FUNC_PAIR: begin
        while (pos < store_count && store_time[pos] < item.time_ms) pos++;
        if (store_count < 2 || pos == 0 || pos >= store_count) begin
          r.status = STATUS_NONE;
        end else begin
          tp = store_time[pos-1];
          tn = store_time[pos];
          num = {32'd0, item.time_ms - tp};
          den = {32'd0, tn - tp};
          r.found_handle = store_handle[pos-1];
          r.found_time = tp;
          r.later_handle = store_handle[pos];
          r.blend_factor = (den != 0) ? 17'((num << TfbFactorBits) / den) : 17'd0;
        end
      end
      default: begin
        store_count = 0;
        last_taken = '1;
      end
    endcase
    r.entry_count = 6'(store_count);
    r.span_ms = span_now();
    return r;
  endfunction

  // Result side: compare each strobe with the oldest expectation.
  always @(posedge clk) begin
    tfb_out_t want;
    if (rst_n && out_valid) begin
      result_count <= result_count + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: actual %h", $time, out_data);
        error_count <= error_count + 1;
      end else begin
        want = expected_results.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch: expected %h actual %h", $time, want, out_data);
          $display("  status %0d/%0d handle %0d/%0d time %0d/%0d later %0d/%0d",
                   want.status, out_data.status, want.found_handle,
                   out_data.found_handle, want.found_time, out_data.found_time,
                   want.later_handle, out_data.later_handle);
          $display("  blend %0d/%0d count %0d/%0d span %0d/%0d",
                   want.blend_factor, out_data.blend_factor, want.entry_count,
                   out_data.entry_count, want.span_ms, out_data.span_ms);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Hold start until the transfer edge; busy rises after it. Hand back the
  // predicted result of the transfer.
  task automatic send_item(input tfb_in_t item, input bit idle_ok,
                           output tfb_out_t want);
    int gap;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer happens at this edge
    want = buffer_apply(item);
    if (want.status == STATUS_FULL) full_hits++;
    if (want.status == STATUS_NONE) none_hits++;
    expected_results = {expected_results, want};
    transfer_count++;
    start <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic tfb_in_t make_item(logic [1:0] f, logic [31:0] t, logic [7:0] h);
    tfb_in_t it;
    it.func = f;
    it.time_ms = t;
    it.frame_handle = h;
    return it;
  endfunction

  // Random timestamps: mostly near a moving base, sometimes anywhere.
  function automatic logic [31:0] rand_time(logic [31:0] base);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 50);
      2: return 32'(base);
      default: return base + $urandom_range(0, 400) - 100;
    endcase
  endfunction

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    tfb_out_t got;
    tfb_in_t item;
    logic [31:0] base;
    int pick;
    int drain;

    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    error_count = 0;
    result_count = 0;
    transfer_count = 0;
    cycle_count = 0;
    full_hits = 0;
    none_hits = 0;
    store_count = 0;
    last_taken = '1;

    // Directed table: empty-store cases, extremes, ties, a wrap-sized span.
    row = '{make_item(FUNC_TAKE, 32'hFFFF_FFFF, 8'h00), 1'b1, '0};
    row.want.status = STATUS_NONE;
    rows = {rows, row};
    row = '{make_item(FUNC_PAIR, 32'd5, 8'h00), 1'b1, '0};
    row.want.status = STATUS_NONE;
    rows = {rows, row};
    row = '{make_item(FUNC_CLEAR, 32'hFFFF_FFFF, 8'hFF), 1'b1, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_INSERT, 32'd0, 8'hFF), 1'b1, '0};
    row.want.entry_count = 6'd1;
    rows = {rows, row};
    row = '{make_item(FUNC_INSERT, 32'hFFFF_FFFF, 8'h00), 1'b1, '0};
    row.want.entry_count = 6'd2;
    row.want.span_ms = 32'hFFFF_FFFF;
    rows = {rows, row};
    row = '{make_item(FUNC_PAIR, 32'hFFFF_FFFF, 8'h00), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_PAIR, 32'd0, 8'h00), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_PAIR, 32'd1, 8'h00), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_INSERT, 32'd100, 8'hA5), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_INSERT, 32'd100, 8'h5A), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_PAIR, 32'd100, 8'h00), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_PAIR, 32'd101, 8'h00), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_TAKE, 32'd100, 8'h00), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_TAKE, 32'd50, 8'h00), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_CLEAR, 32'd0, 8'h00), 1'b1, '0};
    rows = {rows, row};
    // fill to DEPTH with descending times, then one insert past full
    for (int i = 0; i < Depth; i++) begin
      row = '{make_item(FUNC_INSERT, 32'(1000 - 7 * i), 8'(i)), 1'b0, '0};
      rows = {rows, row};
    end
    row = '{make_item(FUNC_INSERT, 32'd1, 8'h33), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(FUNC_TAKE, 32'hFFFF_FFFF, 8'h00), 1'b0, '0};
    rows = {rows, row};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; typed rows are compared with the predictor's answer.
    foreach (rows[i]) begin
      send_item(rows[i].item, 1'b1, got);
      if (rows[i].check_row) begin
        if (got !== rows[i].want) begin
          $display("%0t: directed row %0d: expected %h actual %h", $time, i,
                   rows[i].want, got);
          error_count++;
        end
      end
    end

    // Random part: insert-heavy with takes and pair queries around a base
    // that advances, so the store fills, drains and hits full now and then.
    base = $urandom_range(0, 1000);
    for (int n = 0; n < 520; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        item = make_item(FUNC_INSERT, rand_time(base), 8'($urandom()));
      end else if (pick < 70) begin
        item = make_item(FUNC_TAKE, rand_time(base), 8'($urandom()));
        base = base + $urandom_range(0, 60);
      end else if (pick < 97) begin
        item = make_item(FUNC_PAIR, rand_time(base), 8'($urandom()));
      end else begin
        item = make_item(FUNC_CLEAR, $urandom(), 8'($urandom()));
      end
      send_item(item, n < 440, got);
    end

    // Drain: wait for outstanding results, then a short settle.
    drain = 0;
    while (expected_results.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               expected_results.size());
      error_count++;
    end

    $display("Ran %0d transfers, %0d results checked (%0d full rejects, %0d none).",
             transfer_count, result_count, full_hits, none_hits);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    wait (cycle_count >= MaxCycles);
    $display("%0t: timeout", $time);
    $display("FAIL");
    $finish;
  end

endmodule

>>> timestamp_frame_buffer_top.f
design/tfb_pkg.sv
design/timestamp_frame_buffer_top.sv
bench/timestamp_frame_buffer_top_tb.sv
